// ===== design/rhsv_pkg.sv =====
package rhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_SIXTH    = 3840;
    localparam int HUE_TURN     = 23040;
    localparam int HUE_BITS     = 15;
    localparam int HQ_BITS      = $clog2(HUE_SIXTH + 1);
    localparam int NCELLS       = (HQ_BITS > CHANNEL_BITS) ? HQ_BITS : CHANNEL_BITS;
    localparam int DIV_W        = CHANNEL_BITS + NCELLS;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [DIV_W-1:0]        div_word_t;
    typedef logic [NCELLS-1:0]       quot_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    typedef struct packed {
        div_word_t hue_rem;
        div_word_t hue_dsr;
        quot_t     hue_q;
        div_word_t sat_rem;
        div_word_t sat_dsr;
        quot_t     sat_q;
        sector_t   sector;
        logic      neg;
        logic      grey;
        chan_t     value;
    } div_ctx_t;

endpackage

// ===== design/rhsv_if.sv =====
interface rhsv_pix_if;
    logic                                valid;
    logic                                ready;
    logic [rhsv_pkg::CHANNEL_BITS-1:0]   red_in;
    logic [rhsv_pkg::CHANNEL_BITS-1:0]   green_in;
    logic [rhsv_pkg::CHANNEL_BITS-1:0]   blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rhsv_hsv_if;
    logic                                valid;
    logic                                ready;
    logic [rhsv_pkg::HUE_BITS-1:0]       hue_out;
    logic [rhsv_pkg::CHANNEL_BITS-1:0]   saturation_out;
    logic [rhsv_pkg::CHANNEL_BITS-1:0]   value_out;

    modport source (output valid, output hue_out, output saturation_out, output value_out,
                    input ready);
    modport sink   (input valid, input hue_out, input saturation_out, input value_out,
                    output ready);
endinterface

// ===== design/rhsv_front.sv =====
module rhsv_front (
    input  logic               clk,
    input  logic               rst_n,
    rhsv_pix_if.sink           pix,
    output logic               valid_out,
    input  logic               ready_dn,
    output rhsv_pkg::div_ctx_t ctx_out
);
    import rhsv_pkg::*;

    logic                  valid_reg;
    logic                  ready_up;
    div_ctx_t              ctx_reg;
    div_ctx_t              ctx_next;
    chan_t                 hi;
    chan_t                 lo;
    chan_t                 delta;
    chan_t                 mag;
    logic [CHANNEL_BITS:0] num;
    sector_t               sector;

    assign ready_up  = !valid_reg || ready_dn;
    assign pix.ready = ready_up;
    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;

    always_comb
    begin
        if (pix.red_in >= pix.green_in && pix.red_in >= pix.blue_in)
        begin
            sector = SECTOR_RED;
            hi     = pix.red_in;
            num    = {1'b0, pix.green_in} - {1'b0, pix.blue_in};
        end
        else if (pix.green_in >= pix.blue_in)
        begin
            sector = SECTOR_GREEN;
            hi     = pix.green_in;
            num    = {1'b0, pix.blue_in} - {1'b0, pix.red_in};
        end
        else
        begin
            sector = SECTOR_BLUE;
            hi     = pix.blue_in;
            num    = {1'b0, pix.red_in} - {1'b0, pix.green_in};
        end

        lo = pix.red_in;
        if (pix.green_in < lo)
        begin
            lo = pix.green_in;
        end
        if (pix.blue_in < lo)
        begin
            lo = pix.blue_in;
        end

        delta = hi - lo;
        mag   = num[CHANNEL_BITS] ? CHANNEL_BITS'(-num) : num[CHANNEL_BITS-1:0];

        ctx_next.hue_rem = DIV_W'(mag) * DIV_W'(HUE_SIXTH);
        ctx_next.hue_dsr = DIV_W'(delta) << (NCELLS - 1);
        ctx_next.hue_q   = '0;
        ctx_next.sat_rem = (DIV_W'(delta) << CHANNEL_BITS) - DIV_W'(delta);
        ctx_next.sat_dsr = DIV_W'(hi) << (NCELLS - 1);
        ctx_next.sat_q   = '0;
        ctx_next.sector  = sector;
        ctx_next.neg     = num[CHANNEL_BITS];
        ctx_next.grey    = (delta == '0);
        ctx_next.value   = hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && pix.valid)
        begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

// ===== design/rhsv_div_cell.sv =====
module rhsv_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               ready_up,
    input  rhsv_pkg::div_ctx_t ctx_in,
    output logic               valid_out,
    input  logic               ready_dn,
    output rhsv_pkg::div_ctx_t ctx_out
);
    import rhsv_pkg::*;

    logic     valid_reg;
    div_ctx_t ctx_reg;
    div_ctx_t ctx_next;
    logic     hue_take;
    logic     sat_take;

    assign ready_up  = !valid_reg || ready_dn;
    assign valid_out = valid_reg;
    assign ctx_out   = ctx_reg;

    always_comb
    begin
        ctx_next = ctx_in;
        hue_take = (ctx_in.hue_rem >= ctx_in.hue_dsr);
        sat_take = (ctx_in.sat_rem >= ctx_in.sat_dsr);
        if (hue_take)
        begin
            ctx_next.hue_rem = ctx_in.hue_rem - ctx_in.hue_dsr;
        end
        if (sat_take)
        begin
            ctx_next.sat_rem = ctx_in.sat_rem - ctx_in.sat_dsr;
        end
        ctx_next.hue_q   = {ctx_in.hue_q[NCELLS-2:0], hue_take};
        ctx_next.sat_q   = {ctx_in.sat_q[NCELLS-2:0], sat_take};
        ctx_next.hue_dsr = ctx_in.hue_dsr >> 1;
        ctx_next.sat_dsr = ctx_in.sat_dsr >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

// ===== design/rhsv_back.sv =====
module rhsv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               ready_up,
    input  rhsv_pkg::div_ctx_t ctx_in,
    rhsv_hsv_if.source         hsv
);
    import rhsv_pkg::*;

    logic  valid_reg;
    hue_t  hue_reg;
    hue_t  hue_next;
    chan_t sat_reg;
    chan_t sat_next;
    chan_t value_reg;
    hue_t  hq;
    hue_t  base;

    assign ready_up           = !valid_reg || hsv.ready;
    assign hsv.valid          = valid_reg;
    assign hsv.hue_out        = hue_reg;
    assign hsv.saturation_out = sat_reg;
    assign hsv.value_out      = value_reg;

    always_comb
    begin
        hq = HUE_BITS'(ctx_in.hue_q[HQ_BITS-1:0]);
        unique case (ctx_in.sector)
            SECTOR_RED:   base = '0;
            SECTOR_GREEN: base = HUE_BITS'(2 * HUE_SIXTH);
            SECTOR_BLUE:  base = HUE_BITS'(4 * HUE_SIXTH);
            default:      base = '0;
        endcase

        if (ctx_in.grey)
        begin
            hue_next = '0;
        end
        else if (ctx_in.neg)
        begin
            if (ctx_in.sector == SECTOR_RED && hq != '0)
            begin
                hue_next = HUE_BITS'(HUE_TURN) - hq;
            end
            else
            begin
                hue_next = base - hq;
            end
        end
        else
        begin
            hue_next = base + hq;
        end

        sat_next = ctx_in.grey ? '0 : ctx_in.sat_q[CHANNEL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= ctx_in.value;
        end
    end

`ifndef ASSERT_OFF
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hue_reg < HUE_BITS'(HUE_TURN))
        else $error("hue beyond one turn");

    a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && value_reg == '0) |-> (sat_reg == '0 && hue_reg == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_in && ready_up) |=> valid_reg)
        else $error("accepted beat lost at output register");
`endif

endmodule

// ===== design/rgb_to_hsv_convert.sv =====
// Path: the front register, then the NCELLS divider cells, then the output register.
// Throughput: one pixel per cycle unless the output stalls; each of the NCELLS
// divider stages resolves one quotient bit of hue and of saturation for its own pixel.
// Reset: asynchronous, active low; clears the valid flags of every stage only.
module rgb_to_hsv_convert (
    input  logic       clk,
    input  logic       rst_n,
    rhsv_pix_if.sink   pix,
    rhsv_hsv_if.source hsv
);
    import rhsv_pkg::*;

    logic     stage_valid [NCELLS+1];
    logic     stage_ready [NCELLS+1];
    div_ctx_t stage_ctx   [NCELLS+1];

    rhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .valid_out (stage_valid[0]),
        .ready_dn  (stage_ready[0]),
        .ctx_out   (stage_ctx[0])
    );

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_div
        rhsv_div_cell u_div_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[i]),
            .ready_up  (stage_ready[i]),
            .ctx_in    (stage_ctx[i]),
            .valid_out (stage_valid[i+1]),
            .ready_dn  (stage_ready[i+1]),
            .ctx_out   (stage_ctx[i+1])
        );
    end

    rhsv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (stage_valid[NCELLS]),
        .ready_up (stage_ready[NCELLS]),
        .ctx_in   (stage_ctx[NCELLS]),
        .hsv      (hsv)
    );

endmodule

// ===== sim/hsv_result_check.sv =====
`timescale 1ns / 1ps

module hsv_result_check
    import rhsv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  pix_valid,
    input  logic  pix_ready,
    input  chan_t red_in,
    input  chan_t green_in,
    input  chan_t blue_in,
    input  logic  hsv_valid,
    input  logic  hsv_ready,
    input  hue_t  hue_out,
    input  chan_t saturation_out,
    input  chan_t value_out,
    output int    fail_count,
    output int    pending
);

    localparam int CHAN_FULL = (1 << CHANNEL_BITS) - 1;

    typedef struct packed {
        hue_t  hue;
        chan_t sat;
        chan_t val;
    } hsv_t;

    hsv_t expected_hsv[$];

    function automatic hsv_t hsv_from_rgb(chan_t r, chan_t g, chan_t b);
        int   ri;
        int   gi;
        int   bi;
        int   hi;
        int   lo;
        int   delta;
        int   h;
        hsv_t res;
        ri = r;
        gi = g;
        bi = b;
        hi = ri;
        lo = ri;
        if (gi > hi) hi = gi;
        if (bi > hi) hi = bi;
        if (gi < lo) lo = gi;
        if (bi < lo) lo = bi;
        delta = hi - lo;
        h = 0;
        res.sat = '0;
        if (delta > 0)
        begin
            // max channel picks the sector, ties go red, then green
            if (hi == ri)
                h = ((gi - bi) * HUE_SIXTH) / delta;
            else if (hi == gi)
                h = 2 * HUE_SIXTH + ((bi - ri) * HUE_SIXTH) / delta;
            else
                h = 4 * HUE_SIXTH + ((ri - gi) * HUE_SIXTH) / delta;
            if (h < 0)
                h = h + HUE_TURN;
            res.sat = chan_t'((delta * CHAN_FULL) / hi);
        end
        res.hue = hue_t'(h);
        res.val = chan_t'(hi);
        return res;
    endfunction

    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n)
        begin
            if (hsv_valid && hsv_ready)
            begin
                if (expected_hsv.size() == 0)
                begin
                    $display("%0t: result beat with none pending: hue %0d sat %0d val %0d",
                             $time, hue_out, saturation_out, value_out);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    if (hue_out !== want.hue)
                    begin
                        $display("%0t: hue mismatch: expected %0d, actual %0d",
                                 $time, want.hue, hue_out);
                        fail_count = fail_count + 1;
                    end
                    if (saturation_out !== want.sat)
                    begin
                        $display("%0t: saturation mismatch: expected %0d, actual %0d",
                                 $time, want.sat, saturation_out);
                        fail_count = fail_count + 1;
                    end
                    if (value_out !== want.val)
                    begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.val, value_out);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (pix_valid && pix_ready)
                expected_hsv.push_back(hsv_from_rgb(red_in, green_in, blue_in));
            pending = expected_hsv.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rhsv_pkg::*;

    localparam int CHAN_MAX_CODE = (1 << CHANNEL_BITS) - 1;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_req_count;
    int   hold_seen;
    int   hold_left;

    rhsv_pix_if pix_bus ();
    rhsv_hsv_if hsv_bus ();

    rgb_to_hsv_convert uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_bus),
        .hsv   (hsv_bus)
    );

    hsv_result_check hsv_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_bus.valid),
        .pix_ready      (pix_bus.ready),
        .red_in         (pix_bus.red_in),
        .green_in       (pix_bus.green_in),
        .blue_in        (pix_bus.blue_in),
        .hsv_valid      (hsv_bus.valid),
        .hsv_ready      (hsv_bus.ready),
        .hue_out        (hsv_bus.hue_out),
        .saturation_out (hsv_bus.saturation_out),
        .value_out      (hsv_bus.value_out),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // entered and left just after a falling edge
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pix_bus.valid    <= 1'b1;
        pix_bus.red_in   <= r;
        pix_bus.green_in <= g;
        pix_bus.blue_in  <= b;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_pixels(input int count);
        chan_t top;
        chan_t other;
        chan_t c0;
        chan_t c1;
        chan_t c2;
        int    kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            c0 = chan_t'($urandom);
            c1 = chan_t'($urandom);
            c2 = chan_t'($urandom);
            if (kind == 0)
            begin
                c1 = c0;
                c2 = c0;
            end
            else if (kind == 1)
            begin
                // two channels share the maximum
                top   = chan_t'($urandom_range(CHAN_MAX_CODE, 1));
                other = chan_t'($urandom_range(top - 1, 0));
                case ($urandom_range(2))
                    0: begin c0 = top; c1 = top; c2 = other; end
                    1: begin c0 = other; c1 = top; c2 = top; end
                    default: begin c0 = top; c1 = other; c2 = top; end
                endcase
            end
            else if (kind == 2)
            begin
                c1 = chan_t'(c0 + $urandom_range(3));
                c2 = chan_t'(c0 + $urandom_range(3));
                if (c1 < c0) c1 = c0;
                if (c2 < c0) c2 = c0;
            end
            send_pixel(c0, c1, c2);
        end
    endtask

    initial
    begin
        hsv_bus.ready = 1'b0;
        hold_left     = 0;
        hold_seen     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hsv_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (hold_req_count != hold_seen)
            begin
                hold_seen = hold_req_count;
                hold_left = 399;
                hsv_bus.ready <= 1'b0;
            end
            else
                hsv_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        pix_bus.valid    = 1'b0;
        pix_bus.red_in   = '0;
        pix_bus.green_in = '0;
        pix_bus.blue_in  = '0;
        rst_n            = 1'b0;
        hold_req_count   = 0;
        send_idle_pct    = 10;
        recv_idle_pct    = 75;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd1);
        send_pixel(8'd100, 8'd101, 8'd100);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd10,  8'd250, 8'd130);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd255, 8'd128, 8'd254);
        send_pixel(8'd85,  8'd170, 8'd0);

        send_random_pixels(440);

        send_idle_pct = 75;
        recv_idle_pct = 10;
        send_random_pixels(445);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_pixels(50);
        // long output stall while pixels keep coming
        hold_req_count = hold_req_count + 1;
        send_random_pixels(395);

        pix_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
